>>> hdl/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

	// Width of the input field; a narrower VALUE_BITS masks it further.
	localparam int FIELD_BITS = 16;
	localparam int VALUE_BITS_DEFAULT = 16;

	// One BCD digit and the ASCII code of '0'.
	localparam int DIGIT_BITS = 4;
	localparam int ASCII_BITS = 6;
	localparam logic [ASCII_BITS-1:0] ASCII_ZERO = 6'd48;
	localparam logic [ASCII_BITS-1:0] ASCII_NINE = 6'd57;

	// Number of words the queue between front and back can hold.
	localparam int QUEUE_DEPTH = 2;

	// Binary bits that actually take part in the conversion.
	function automatic int eff_bits(input int value_bits);
		return (value_bits < FIELD_BITS) ? value_bits : FIELD_BITS;
	endfunction

	// Decimal digits of the largest number of n bits: floor(n * log10 2) + 1.
	function automatic int digit_count(input int n);
		return ((n * 1233) >> 12) + 1;
	endfunction

	// Bits needed to index the digits of one number.
	function automatic int index_bits(input int n);
		return $clog2(digit_count(n));
	endfunction

	// Front controller states.
	typedef enum logic [2:0] {
		FRONT_IDLE = 3'b001,
		FRONT_CONV = 3'b010,
		FRONT_PUSH = 3'b100
	} front_state_t;

endpackage

>>> hdl/bda_front.sv
`timescale 1ns / 1ps

module bda_front
	import bda_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [FIELD_BITS-1:0] value,
	output logic push_valid,
	input  logic push_ready,
	output logic [digit_count(eff_bits(VALUE_BITS))*DIGIT_BITS-1:0] push_bcd,
	output logic [index_bits(eff_bits(VALUE_BITS))-1:0] push_top
);

	localparam int EFF = eff_bits(VALUE_BITS);
	localparam int DIGITS = digit_count(EFF);
	localparam int BCD_BITS = DIGITS * DIGIT_BITS;
	localparam int IW = index_bits(EFF);
	localparam int SW = $clog2(EFF);

	front_state_t state_q;
	logic [EFF-1:0] bin_q;
	logic [BCD_BITS-1:0] bcd_q;
	logic [SW-1:0] step_q;
	logic [BCD_BITS-1:0] bcd_adj;
	logic [IW-1:0] top_w;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
				bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
			end else begin
				bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
			end
		end
	end

	// Classify the result: position of the most significant non-zero digit.
	always_comb begin
		top_w = '0;
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] != 4'd0) begin
				top_w = IW'(i);
			end
		end
	end

	assign in_ready = (state_q == FRONT_IDLE);
	assign push_valid = (state_q == FRONT_PUSH);
	assign push_bcd = bcd_q;
	assign push_top = top_w;

	// Sequencer: load, one shift-and-adjust step a cycle, then hand on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_IDLE;
		end else begin
			unique case (state_q)
				FRONT_IDLE: begin
					if (in_valid) begin
						state_q <= FRONT_CONV;
					end
				end
				FRONT_CONV: begin
					if (step_q == '0) begin
						state_q <= FRONT_PUSH;
					end
				end
				FRONT_PUSH: begin
					if (push_ready) begin
						state_q <= FRONT_IDLE;
					end
				end
				default: begin
					state_q <= FRONT_IDLE;
				end
			endcase
		end
	end

	// Conversion datapath.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bin_q <= value[EFF-1:0];
			bcd_q <= '0;
			step_q <= SW'(EFF - 1);
		end else if (state_q == FRONT_CONV) begin
			bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[EFF-1]};
			bin_q <= {bin_q[EFF-2:0], 1'b0};
			step_q <= step_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	// The last conversion step always leads to the hand-over state.
	a_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FRONT_CONV && step_q == '0) |=> (state_q == FRONT_PUSH))
		else $error("front did not finish conversion after the final step");
`endif

endmodule

>>> hdl/bda_fifo.sv
`timescale 1ns / 1ps

module bda_fifo
	import bda_pkg::*;
#(
	parameter int DATA_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic [DATA_BITS-1:0] push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push_w;
	logic pop_w;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push_w = push_valid && push_ready;
	assign pop_w = pop_valid && pop_ready;

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (push_w) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_w) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_w) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_w && !pop_w) begin
				count_q <= count_q + 1'b1;
			end else if (pop_w && !push_w) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The fill level never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill level beyond its depth");

	// A lone push raises the fill level by exactly one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push_w && !pop_w) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill level wrong after a push");
`endif

endmodule

>>> hdl/bda_back.sv
`timescale 1ns / 1ps

module bda_back
	import bda_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic [digit_count(eff_bits(VALUE_BITS))*DIGIT_BITS-1:0] pop_bcd,
	input  logic [index_bits(eff_bits(VALUE_BITS))-1:0] pop_top,
	output logic out_valid,
	input  logic out_ready,
	output logic [ASCII_BITS-1:0] ascii_digit,
	output logic last_digit
);

	localparam int EFF = eff_bits(VALUE_BITS);
	localparam int DIGITS = digit_count(EFF);
	localparam int IW = index_bits(EFF);

	logic busy_q;
	logic [DIGIT_BITS-1:0] dig_q [DIGITS];
	logic [IW-1:0] idx_q;
	logic out_valid_q;
	logic [ASCII_BITS-1:0] ascii_q;
	logic last_q;
	logic load_w;

	assign pop_ready = !busy_q;
	assign load_w = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign ascii_digit = ascii_q;
	assign last_digit = last_q;

	// Take a converted number from the queue, then walk its digits downwards.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
			end else if (load_w && idx_q == '0) begin
				busy_q <= 1'b0;
			end
			if (load_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit store, digit index and output word.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			for (int i = 0; i < DIGITS; i++) begin
				dig_q[i] <= pop_bcd[i*DIGIT_BITS +: DIGIT_BITS];
			end
			idx_q <= pop_top;
		end else if (load_w) begin
			idx_q <= idx_q - 1'b1;
		end
		if (load_w) begin
			ascii_q <= ASCII_ZERO + {{(ASCII_BITS-DIGIT_BITS){1'b0}}, dig_q[idx_q]};
			last_q <= (idx_q == '0);
		end
	end

`ifndef NO_ASSERTIONS
	// Every word shown is a decimal digit character.
	a_ascii_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ascii_q >= ASCII_ZERO && ascii_q <= ASCII_NINE))
		else $error("output word is not a decimal digit");

	// Loading the units digit flags it last and frees the back end.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(load_w && idx_q == '0) |=> (last_q && !busy_q))
		else $error("units digit not flagged last or back end still busy");
`endif

endmodule

>>> hdl/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps

// Channel | Handshake           | Word
// input   | in_valid, in_ready  | value[15:0], unsigned binary number
// output  | out_valid, out_ready| ascii_digit[5:0], last_digit (set on the units digit)
//
// The front end takes a number only when idle, runs min(VALUE_BITS, 16) steps of
// shift-and-adjust, then waits in its hand-over state for room in the queue; it is
// idle again once the number is handed on. The back end then emits one character per
// cycle while out_ready is high, 1 to 5 per number, from an output register; a two-word
// queue lets the two ends run on separate numbers.
// Reset is asynchronous and active low; it clears only control state.
// A stalled output fills the queue and then holds in_ready low.

module binary_to_decimal_ascii_top
	import bda_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [FIELD_BITS-1:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic [ASCII_BITS-1:0] ascii_digit,
	output logic last_digit
);

	localparam int EFF = eff_bits(VALUE_BITS);
	localparam int BCD_BITS = digit_count(EFF) * DIGIT_BITS;
	localparam int IW = index_bits(EFF);
	localparam int QW = BCD_BITS + IW;

	logic push_valid;
	logic push_ready;
	logic [BCD_BITS-1:0] push_bcd;
	logic [IW-1:0] push_top;
	logic pop_valid;
	logic pop_ready;
	logic [QW-1:0] pop_data;

	// Conversion front end.
	bda_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_bcd(push_bcd),
		.push_top(push_top)
	);

	// Queue of converted numbers.
	bda_fifo #(
		.DATA_BITS(QW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data({push_bcd, push_top}),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	// Character emission back end.
	bda_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_bcd(pop_data[QW-1:IW]),
		.pop_top(pop_data[IW-1:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ascii_digit(ascii_digit),
		.last_digit(last_digit)
	);

endmodule

>>> dv/tb_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_top;
	import bda_pkg::*;

	localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
	localparam int CONV_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int unsigned CONV_MASK = (32'd1 << CONV_BITS) - 1;
	localparam int unsigned DECIMAL_BASE = 10;
	localparam int MAX_CHARS = 5;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_NUMBERS = 350;
	localparam int PRESSURE_NUMBERS = 25;
	localparam int REPORT_LIMIT = 10;

	// Receiver behaviour between long hold-offs.
	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_SELDOM,
		RX_PERIODIC
	} rx_mode_t;

	// One expected character word.
	typedef struct packed {
		logic [ASCII_BITS-1:0] code;
		logic last;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FIELD_BITS-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ASCII_BITS-1:0] ascii_digit;
	logic last_digit;

	char_word_t pending_chars[$];
	int error_count = 0;
	int numbers_sent = 0;
	int chars_checked = 0;
	int input_stall_cycles = 0;
	int length_seen[1:MAX_CHARS] = '{default: 0};
	logic hold_request = 1'b0;

	binary_to_decimal_ascii_top #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ascii_digit(ascii_digit),
		.last_digit(last_digit)
	);

	always #10 clk = ~clk;

	// Decimal text of one number, most significant character first.
	function automatic void predict_text(input logic [FIELD_BITS-1:0] number);
		int unsigned rest;
		int digits[$];
		char_word_t word;
		rest = number & CONV_MASK;
		do begin
			digits.push_front(rest % DECIMAL_BASE);
			rest = rest / DECIMAL_BASE;
		end while (rest != 0);
		length_seen[digits.size()]++;
		foreach (digits[k]) begin
			word.code = ASCII_ZERO + ASCII_BITS'(digits[k]);
			word.last = (k == digits.size() - 1);
			pending_chars.push_back(word);
		end
	endfunction

	// Random number, mostly with an evenly chosen count of decimal digits.
	function automatic logic [FIELD_BITS-1:0] pick_number();
		int unsigned n_digits;
		int unsigned low;
		int unsigned high;
		if ($urandom_range(0, 3) == 0) begin
			return FIELD_BITS'($urandom);
		end
		n_digits = $urandom_range(1, MAX_CHARS);
		low = 1;
		repeat (n_digits - 1) low = low * DECIMAL_BASE;
		high = low * DECIMAL_BASE - 1;
		if (n_digits == 1) begin
			low = 0;
		end
		if (high > CONV_MASK) high = CONV_MASK;
		if (low > high) low = 0;
		return FIELD_BITS'($urandom_range(high, low));
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send_number(input logic [FIELD_BITS-1:0] number);
		in_valid <= 1'b1;
		value <= number;
		@(posedge clk);
		while (!in_ready) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		predict_text(number);
		numbers_sent++;
	endtask

	// Leave the input channel idle for a number of cycles.
	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			value <= FIELD_BITS'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Field extremes and every change in the number of digits.
	task automatic test_digit_boundaries();
		logic [FIELD_BITS-1:0] corners[] = '{
			16'd0, 16'd1, 16'd9, 16'd10, 16'd19, 16'd90, 16'd99, 16'd100,
			16'd909, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd12345,
			16'd32768, 16'd40000, 16'd54321, 16'h5555, 16'hAAAA,
			16'd65534, 16'd65535
		};
		foreach (corners[k]) begin
			send_number(corners[k]);
		end
	endtask

	// Random numbers sent in bursts with random gaps between them.
	task automatic test_random_bursts();
		int burst_left;
		burst_left = 0;
		for (int k = 0; k < RANDOM_NUMBERS; k++) begin
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
				burst_left = $urandom_range(1, 12);
			end
			send_number(pick_number());
			burst_left--;
		end
	endtask

	// A long receiver hold-off while the sender keeps offering words.
	task automatic test_output_hold_off();
		hold_request <= 1'b1;
		for (int k = 0; k < PRESSURE_NUMBERS; k++) begin
			send_number(pick_number());
		end
	endtask

	// Receiver: a long hold-off on request, otherwise a changing stall pattern.
	initial begin
		int hold_left;
		int mode_left;
		int phase;
		rx_mode_t mode;
		hold_left = 0;
		mode_left = 0;
		phase = 0;
		mode = RX_ALWAYS;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_request) begin
				hold_request <= 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS: begin
						out_ready <= 1'b1;
					end
					RX_MOSTLY: begin
						out_ready <= ($urandom_range(0, 3) != 0);
					end
					RX_SELDOM: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ready <= ((phase % 5) < 2);
					end
				endcase
			end
		end
	end

	// Compare each accepted character word with the oldest expectation.
	always @(posedge clk) begin
		char_word_t wanted;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected word code %0d last %0b", $time,
						ascii_digit, last_digit);
				end
			end else begin
				wanted = pending_chars.pop_front();
				chars_checked++;
				if (ascii_digit !== wanted.code || last_digit !== wanted.last) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("%0t: expected code %0d last %0b, got code %0d last %0b",
							$time, wanted.code, wanted.last, ascii_digit, last_digit);
					end
				end
			end
		end
	end

	// Watchdog: too long without any word moving on either channel.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// Sequence of tests, drain and verdict.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_digit_boundaries();
		test_random_bursts();
		test_output_hold_off();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			error_count += pending_chars.size();
			$display("%0d expected words never arrived", pending_chars.size());
		end
		$display("Converted %0d numbers into %0d characters; by length 1..5: %0d %0d %0d %0d %0d.",
			numbers_sent, chars_checked, length_seen[1], length_seen[2], length_seen[3],
			length_seen[4], length_seen[5]);
		$display("Input held off for %0d cycles, including a %0d-cycle output stall; %0d errors.",
			input_stall_cycles, HOLD_CYCLES, error_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
